// ===== sv/sirs_pkg.sv =====
// sirs_pkg: types and codes for the sorted id range set
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package sirs_pkg;

    localparam int ID_BITS = 32;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_FIND   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] MODE_EITHER = 2'd0;
    localparam logic [1:0] MODE_LEFT   = 2'd1;
    localparam logic [1:0] MODE_RIGHT  = 2'd2;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_DONE    = 3'd1;
    localparam logic [2:0] ST_OVERLAP = 3'd2;
    localparam logic [2:0] ST_INCONS  = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    // cell commands
    localparam logic [1:0] CMD_HOLD  = 2'd0;
    localparam logic [1:0] CMD_SHR   = 2'd1; // take left neighbour's entry
    localparam logic [1:0] CMD_SHL   = 2'd2; // take right neighbour's entry

    typedef struct packed {
        logic [1:0]         operation;
        logic [ID_BITS-1:0] range_low;
        logic [ID_BITS-1:0] range_high;
        logic [1:0]         merge_mode;
        logic [ID_BITS-1:0] query_id;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic [ID_BITS-1:0] gap_low;
        logic [ID_BITS-1:0] gap_high;
        logic               gap_open;
        logic [6:0]         range_count;
    } t_out;

endpackage
`default_nettype wire

// ===== sv/sirs_cell.sv =====
// sirs_cell: one table entry with its predecessor compare
// uses sirs_pkg; chained in sorted_id_range_set
`timescale 1ns / 1ps
`default_nettype none
module sirs_cell
    import sirs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic [1:0]         i_cmd,
    input  wire logic               i_wr_low,
    input  wire logic               i_wr_high,
    input  wire logic [ID_BITS-1:0] i_wdata_low,
    input  wire logic [ID_BITS-1:0] i_wdata_high,
    input  wire logic [ID_BITS-1:0] i_left_low,
    input  wire logic [ID_BITS-1:0] i_left_high,
    input  wire logic [ID_BITS-1:0] i_right_low,
    input  wire logic [ID_BITS-1:0] i_right_high,
    input  wire logic [ID_BITS-1:0] i_key,
    output logic [ID_BITS-1:0]      o_low,
    output logic [ID_BITS-1:0]      o_high,
    output logic                    o_le
);
    logic [ID_BITS-1:0] r_low, r_high;

    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            CMD_SHR: begin
                r_low  <= i_left_low;
                r_high <= i_left_high;
            end
            CMD_SHL: begin
                r_low  <= i_right_low;
                r_high <= i_right_high;
            end
            default: begin
                if (i_wr_low) r_low <= i_wdata_low;
                if (i_wr_high) r_high <= i_wdata_high;
            end
        endcase
    end

    assign o_low  = r_low;
    assign o_high = r_high;
    assign o_le   = (r_low <= i_key);
endmodule
`default_nettype wire

// ===== sv/sorted_id_range_set.sv =====
// sorted id range set: keeps up to MAX_RANGES disjoint id ranges in a chain of
// cells sorted by low id. a transaction is taken only while the block is idle;
// then every cell compares against the key, the predecessor is picked, its
// neighbours are read and the outcome decided, then the chain shifts one place
// and is written while the result loads into the output register. a find that
// starts inside a held range first walks the following cells one per cycle
// before it completes. input is taken again in the cycle in which the result is
// presented, so a new transaction starts only once the last result is
// registered, and a stalled result holds the block in its last step until it
// is taken.
`timescale 1ns / 1ps
`default_nettype none
module sorted_id_range_set
    import sirs_pkg::*;
#(
    parameter int MAX_RANGES = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_in  i_data,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_out      o_data
);
    localparam int IW = $clog2(MAX_RANGES);
    localparam int CW = $clog2(MAX_RANGES + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PRED = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;
    localparam logic [2:0] S_SCAN = 3'd5;

    logic [2:0]          r_state;
    logic [CW-1:0]       r_cnt;
    t_in                 r_in;
    logic [ID_BITS-1:0]  r_key;
    logic [MAX_RANGES-1:0] r_le;
    logic                r_has_p;
    logic [IW-1:0]       r_p;
    logic [IW:0]         r_i;
    logic [ID_BITS:0]    r_nxt;
    t_out                r_res;
    t_out                r_out;

    logic [ID_BITS-1:0] c_low [MAX_RANGES];
    logic [ID_BITS-1:0] c_high[MAX_RANGES];
    logic [MAX_RANGES-1:0] c_le;
    logic [1:0]  cmd [MAX_RANGES];
    logic [MAX_RANGES-1:0] wr_low, wr_high;
    logic [ID_BITS-1:0] wd_low, wd_high;

    // shift plan, registered in decide
    logic          r_sh_en, r_sh_right, r_wl, r_wh;
    logic [IW-1:0] r_sh_pos, r_w_pos;
    logic [ID_BITS-1:0] r_wd_low, r_wd_high;

    genvar g;
    generate
        for (g = 0; g < MAX_RANGES; g++) begin : g_cell
            logic [ID_BITS-1:0] ll, lh, rl, rh;
            if (g == 0) begin : g_l0
                assign ll = '0;
                assign lh = '0;
            end else begin : g_ln
                assign ll = c_low[g-1];
                assign lh = c_high[g-1];
            end
            if (g == MAX_RANGES - 1) begin : g_rl
                assign rl = '0;
                assign rh = '0;
            end else begin : g_rn
                assign rl = c_low[g+1];
                assign rh = c_high[g+1];
            end
            sirs_cell u_cell (
                .i_clk(i_clk), .i_cmd(cmd[g]), .i_wr_low(wr_low[g]),
                .i_wr_high(wr_high[g]), .i_wdata_low(wd_low), .i_wdata_high(wd_high),
                .i_left_low(ll), .i_left_high(lh), .i_right_low(rl), .i_right_high(rh),
                .i_key(r_key), .o_low(c_low[g]), .o_high(c_high[g]), .o_le(c_le[g])
            );
        end
    endgenerate

    assign wd_low  = r_wd_low;
    assign wd_high = r_wd_high;

    // r_cnt already holds the count after the transaction here
    always_comb begin
        for (int k = 0; k < MAX_RANGES; k++) begin
            cmd[k]     = CMD_HOLD;
            wr_low[k]  = 1'b0;
            wr_high[k] = 1'b0;
            if (r_state == S_OUT && r_sh_en) begin
                if (r_sh_right && IW'(k) > r_sh_pos && CW'(k) < r_cnt)
                    cmd[k] = CMD_SHR;
                if (!r_sh_right && IW'(k) >= r_sh_pos && CW'(k) < r_cnt)
                    cmd[k] = CMD_SHL;
            end
            if (r_state == S_OUT && IW'(k) == r_w_pos) begin
                wr_low[k]  = r_wl;
                wr_high[k] = r_wh;
            end
        end
    end

    // predecessor: last set bit among valid entries
    logic          pf;
    logic [IW-1:0] pi;
    always_comb begin
        pf = 1'b0;
        pi = '0;
        for (int k = 0; k < MAX_RANGES; k++)
            if (r_le[k] && CW'(k) < r_cnt) begin
                pf = 1'b1;
                pi = IW'(k);
            end
    end

    // neighbour reads: predecessor, and its successor or the walk position
    logic [ID_BITS-1:0] ph, nl, nh, l0;
    logic               has_n;
    logic [IW:0]        pn;
    logic [IW-1:0]      rd_idx;
    assign pn     = {1'b0, r_p} + 1'b1;
    assign rd_idx = (r_state == S_SCAN) ? r_i[IW-1:0] : pn[IW-1:0];
    assign ph     = c_high[r_p];
    assign nl     = c_low[rd_idx];
    assign nh     = c_high[rd_idx];
    assign l0     = c_low[0];
    assign has_n  = r_has_p ? (pn < (IW+1)'(r_cnt)) : (r_cnt != '0);

    logic [ID_BITS-1:0] lo, hi;
    logic [ID_BITS:0]   hi1, ph1, wh1;
    logic               full;
    assign lo   = r_in.range_low;
    assign hi   = r_in.range_high;
    assign hi1  = {1'b0, hi} + 1'b1;
    assign ph1  = {1'b0, ph} + 1'b1;
    assign wh1  = {1'b0, nh} + 1'b1;
    assign full = (r_cnt == CW'(MAX_RANGES));

    // decide
    t_out               d_res;
    logic [CW-1:0]      d_cnt;
    logic [2:0]         d_st;
    logic               d_walk, d_add, d_adj_l, d_adj_r;
    logic               d_sh_en, d_sh_right, d_wl, d_wh;
    logic [IW-1:0]      d_sh_pos, d_w_pos, d_apos;
    logic [ID_BITS-1:0] d_wd_low, d_wd_high;

    always_comb begin
        d_res      = '0;
        d_cnt      = r_cnt;
        d_st       = ST_OK;
        d_walk     = 1'b0;
        d_add      = 1'b0;
        d_adj_l    = 1'b0;
        d_adj_r    = 1'b0;
        d_apos     = '0;
        d_sh_en    = 1'b0;
        d_sh_right = 1'b0;
        d_sh_pos   = '0;
        d_w_pos    = '0;
        d_wl       = 1'b0;
        d_wh       = 1'b0;
        d_wd_low   = lo;
        d_wd_high  = hi;
        unique case (r_in.operation)
            OP_INSERT: begin
                if (hi < lo) d_st = ST_INCONS;
                else if (!r_has_p) begin
                    if (r_cnt == '0 || hi1 < {1'b0, l0}) d_add = 1'b1;
                    else if (hi1 == {1'b0, l0}) begin
                        if (r_in.merge_mode == MODE_LEFT) d_add = 1'b1;
                        else d_wl = 1'b1;
                    end else d_st = ST_INCONS;
                end else if (lo <= ph) d_st = ST_DONE;
                else begin
                    d_adj_l = ({1'b0, lo} == ph1);
                    d_apos  = pn[IW-1:0];
                    if (!has_n) begin
                        if (d_adj_l && r_in.merge_mode != MODE_RIGHT) begin
                            d_w_pos = r_p;
                            d_wh    = 1'b1;
                        end else d_add = 1'b1;
                    end else if (hi >= nl) d_st = ST_OVERLAP;
                    else begin
                        d_adj_r = (hi1 == {1'b0, nl});
                        if (d_adj_l && d_adj_r) begin
                            if (r_in.merge_mode == MODE_LEFT) begin
                                d_w_pos = r_p;
                                d_wh    = 1'b1;
                            end else if (r_in.merge_mode == MODE_RIGHT) begin
                                d_w_pos = pn[IW-1:0];
                                d_wl    = 1'b1;
                            end else begin
                                d_w_pos   = r_p;
                                d_wh      = 1'b1;
                                d_wd_high = nh;
                                d_sh_en   = 1'b1;
                                d_sh_pos  = pn[IW-1:0];
                                d_cnt     = r_cnt - 1'b1;
                            end
                        end else if (d_adj_l && r_in.merge_mode != MODE_RIGHT) begin
                            d_w_pos = r_p;
                            d_wh    = 1'b1;
                        end else if (d_adj_r && r_in.merge_mode != MODE_LEFT) begin
                            d_w_pos = pn[IW-1:0];
                            d_wl    = 1'b1;
                        end else d_add = 1'b1;
                    end
                end
                if (d_add) begin
                    if (full) d_st = ST_FULL;
                    else begin
                        d_w_pos    = d_apos;
                        d_wl       = 1'b1;
                        d_wh       = 1'b1;
                        d_sh_en    = 1'b1;
                        d_sh_right = 1'b1;
                        d_sh_pos   = d_apos;
                        d_cnt      = r_cnt + 1'b1;
                    end
                end
                d_res.status = d_st;
            end
            OP_FIND: begin
                if (!r_has_p) begin
                    d_res.gap_low = r_key;
                    if (r_cnt == '0) d_res.gap_open = 1'b1;
                    else d_res.gap_high = l0 - 1'b1;
                end else if (r_key > ph) begin
                    d_res.gap_low = r_key;
                    if (!has_n) d_res.gap_open = 1'b1;
                    else d_res.gap_high = nl - 1'b1;
                end else d_walk = 1'b1;
            end
            OP_CLEAR: d_cnt = '0;
            default: ;
        endcase
        d_res.range_count = 7'(d_cnt);
    end

    logic out_load;
    assign out_load = (r_state == S_OUT) && (!o_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_sh_en <= 1'b0;
            r_wl    <= 1'b0;
            r_wh    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= out_load || (o_valid && i_stall);
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_in  <= i_data;
                        r_key <= (i_data.operation == OP_FIND) ?
                                 i_data.query_id : i_data.range_low;
                        r_state <= S_PRED;
                    end
                end
                S_PRED: begin
                    r_le    <= c_le;
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_has_p <= pf;
                    r_p     <= pi;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    r_res      <= d_res;
                    r_cnt      <= d_cnt;
                    r_sh_en    <= d_sh_en;
                    r_sh_right <= d_sh_right;
                    r_sh_pos   <= d_sh_pos;
                    r_w_pos    <= d_w_pos;
                    r_wl       <= d_wl;
                    r_wh       <= d_wh;
                    r_wd_low   <= d_wd_low;
                    r_wd_high  <= d_wd_high;
                    r_nxt      <= ph1;
                    r_i        <= pn;
                    r_state    <= d_walk ? S_SCAN : S_OUT;
                end
                S_SCAN: begin
                    // walk one cell per cycle
                    if (r_i < (IW+1)'(r_cnt) && r_nxt >= {1'b0, nl}) begin
                        r_nxt <= wh1;
                        r_i   <= r_i + 1'b1;
                    end else begin
                        r_state <= S_OUT;
                        if (r_i < (IW+1)'(r_cnt)) begin
                            r_res.gap_low  <= r_nxt[ID_BITS-1:0];
                            r_res.gap_high <= nl - 1'b1;
                        end else if (r_nxt[ID_BITS]) begin
                            r_res.status <= ST_DONE;
                        end else begin
                            r_res.gap_low  <= r_nxt[ID_BITS-1:0];
                            r_res.gap_open <= 1'b1;
                        end
                    end
                end
                S_OUT: begin
                    r_sh_en <= 1'b0;
                    r_wl    <= 1'b0;
                    r_wh    <= 1'b0;
                    if (out_load) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_data  = r_out;
endmodule
`default_nettype wire

// ===== sv/sirs_checker.sv =====
// sirs_checker: port-level checks for sorted_id_range_set
// uses sirs_pkg; bound to the top level below
`timescale 1ns / 1ps
`default_nettype none
module sirs_checker
    import sirs_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic o_stall,
    input wire t_out o_data,
    input wire logic o_valid,
    input wire logic i_stall
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data)) else $error("result dropped");
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.status <= ST_FULL) else $error("bad status");
    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.gap_open |-> o_data.gap_high == '0) else $error("open gap high");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall) else $error("accepted while busy");
endmodule

bind sorted_id_range_set sirs_checker u_chk (.*);
`default_nettype wire

// ===== tb/tb_sorted_id_range_set.sv =====
// tb_sorted_id_range_set: self-checking testbench for the sorted id range set
// depends on sirs_pkg and sorted_id_range_set; drives random and directed
// transactions and checks every result against a behavioural predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_sorted_id_range_set;
    import sirs_pkg::*;

    localparam int RANGE_SLOTS = 64;
    localparam int IDLE_PCT    = 27;
    localparam int WATCHDOG    = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in  i_data = '0;
    logic o_valid;
    logic i_stall = 1'b1;
    t_out o_data;

    sorted_id_range_set dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    always #2 i_clk = ~i_clk;

    // predictor state, ids held one bit wider
    logic [32:0] tbl_low [RANGE_SLOTS];
    logic [32:0] tbl_high[RANGE_SLOTS];
    int          tbl_used = 0;

    t_in  pending_q[$];
    t_out expected_q[$];
    int   errors = 0;
    bit   no_idle = 0;
    bit   hold_rx = 0;
    int   quiet_cycles = 0;

    function automatic int pred_of(logic [32:0] id);
        int p;
        p = -1;
        for (int i = 0; i < tbl_used; i++)
            if (tbl_low[i] <= id) p = i;
        return p;
    endfunction

    function automatic logic [2:0] add_range(int pos, logic [32:0] lo, logic [32:0] hi);
        if (tbl_used >= RANGE_SLOTS) return ST_FULL;
        for (int i = tbl_used; i > pos; i--) begin
            tbl_low[i]  = tbl_low[i-1];
            tbl_high[i] = tbl_high[i-1];
        end
        tbl_low[pos]  = lo;
        tbl_high[pos] = hi;
        tbl_used++;
        return ST_OK;
    endfunction

    function automatic logic [2:0] insert_range(logic [32:0] lo, logic [32:0] hi,
                                                logic [1:0] mode);
        int  p;
        bit  adj_l, adj_r;
        if (hi < lo) return ST_INCONS;
        p = pred_of(lo);
        if (p < 0) begin
            if (tbl_used == 0 || hi + 1 < tbl_low[0]) return add_range(0, lo, hi);
            if (hi + 1 == tbl_low[0]) begin
                if (mode == MODE_LEFT) return add_range(0, lo, hi);
                tbl_low[0] = lo;
                return ST_OK;
            end
            return ST_INCONS;
        end
        if (lo <= tbl_high[p]) return ST_DONE;
        adj_l = (lo == tbl_high[p] + 1);
        if (p + 1 >= tbl_used) begin
            if (adj_l && mode != MODE_RIGHT) begin
                tbl_high[p] = hi;
                return ST_OK;
            end
            return add_range(p + 1, lo, hi);
        end
        if (hi >= tbl_low[p+1]) return ST_OVERLAP;
        adj_r = (hi + 1 == tbl_low[p+1]);
        if (adj_l && adj_r) begin
            if (mode == MODE_LEFT) tbl_high[p] = hi;
            else if (mode == MODE_RIGHT) tbl_low[p+1] = lo;
            else begin
                tbl_high[p] = tbl_high[p+1];
                for (int i = p + 1; i + 1 < tbl_used; i++) begin
                    tbl_low[i]  = tbl_low[i+1];
                    tbl_high[i] = tbl_high[i+1];
                end
                tbl_used--;
            end
            return ST_OK;
        end
        if (adj_l && mode != MODE_RIGHT) begin
            tbl_high[p] = hi;
            return ST_OK;
        end
        if (adj_r && mode != MODE_LEFT) begin
            tbl_low[p+1] = lo;
            return ST_OK;
        end
        return add_range(p + 1, lo, hi);
    endfunction

    function automatic t_out find_gap(logic [32:0] id);
        t_out        r;
        int          p;
        logic [32:0] nxt;
        r = '0;
        p = pred_of(id);
        if (p < 0) begin
            r.gap_low = id[31:0];
            if (tbl_used == 0) r.gap_open = 1'b1;
            else r.gap_high = 32'(tbl_low[0] - 1);
            return r;
        end
        if (id > tbl_high[p]) begin
            r.gap_low = id[31:0];
            if (p + 1 >= tbl_used) r.gap_open = 1'b1;
            else r.gap_high = 32'(tbl_low[p+1] - 1);
            return r;
        end
        nxt = tbl_high[p] + 1;
        for (int i = p + 1; i < tbl_used; i++) begin
            if (nxt >= tbl_low[i]) nxt = tbl_high[i] + 1;
            else begin
                r.gap_low  = nxt[31:0];
                r.gap_high = 32'(tbl_low[i] - 1);
                return r;
            end
        end
        if (nxt[32]) begin
            r.status = ST_DONE;
            return r;
        end
        r.gap_low  = nxt[31:0];
        r.gap_open = 1'b1;
        return r;
    endfunction

    function automatic t_out range_set_result(t_in t);
        t_out r;
        r = '0;
        if (t.operation == OP_INSERT)
            r.status = insert_range({1'b0, t.range_low}, {1'b0, t.range_high}, t.merge_mode);
        else if (t.operation == OP_FIND)
            r = find_gap({1'b0, t.query_id});
        else if (t.operation == OP_CLEAR)
            tbl_used = 0;
        r.range_count = 7'(tbl_used);
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || !o_stall) begin
                if (i_valid) expected_q.push_back(range_set_result(i_data));
                if (pending_q.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                    i_valid <= 1'b1;
                    i_data  <= pending_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result status=%0d", o_data.status);
                    errors++;
                end else begin
                    e = expected_q.pop_front();
                    if (o_data.status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, o_data.status); errors++;
                    end
                    if (o_data.gap_low !== e.gap_low) begin
                        $error("gap_low exp %h got %h", e.gap_low, o_data.gap_low); errors++;
                    end
                    if (o_data.gap_high !== e.gap_high) begin
                        $error("gap_high exp %h got %h", e.gap_high, o_data.gap_high); errors++;
                    end
                    if (o_data.gap_open !== e.gap_open) begin
                        $error("gap_open exp %0d got %0d", e.gap_open, o_data.gap_open); errors++;
                    end
                    if (o_data.range_count !== e.range_count) begin
                        $error("range_count exp %0d got %0d", e.range_count,
                               o_data.range_count);
                        errors++;
                    end
                end
            end
            i_stall <= hold_rx || (!no_idle && $urandom_range(99) < IDLE_PCT);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n || hold_rx)
            quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG) begin
            $display("sorted_id_range_set: mismatch");
            $finish;
        end
    end

    function automatic t_in mk(logic [1:0] op, logic [31:0] lo, logic [31:0] hi,
                               logic [1:0] mode, logic [31:0] qid);
        t_in t;
        t.operation = op; t.range_low = lo; t.range_high = hi;
        t.merge_mode = mode; t.query_id = qid;
        return t;
    endfunction

    task automatic drain();
        while (pending_q.size() > 0 || i_valid || expected_q.size() > 0)
            @(posedge i_clk);
    endtask

    // id from a small window near a base, mostly, to force adjacency
    function automatic logic [31:0] near_id(logic [31:0] base);
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'hFFFF_FFFF - $urandom_range(40);
            default: return base + $urandom_range(120);
        endcase
    endfunction

    function automatic t_in rand_item(logic [31:0] base);
        t_in         t;
        logic [31:0] lo;
        int          r;
        r  = $urandom_range(99);
        lo = near_id(base);
        t  = mk(OP_INSERT, lo, lo + $urandom_range(6), 2'($urandom_range(3)),
                near_id(base));
        if (r < 3) t.operation = OP_CLEAR;
        else if (r < 4) t.operation = OP_NONE;
        else if (r < 35) t.operation = OP_FIND;
        else if (r < 40) t.range_high = $urandom;
        if ($urandom_range(9) == 0) t.query_id = $urandom;
        return t;
    endfunction

    initial begin
        logic [31:0] base;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        pending_q.push_back(mk(OP_FIND, 0, 0, MODE_EITHER, 32'h1234));
        pending_q.push_back(mk(OP_INSERT, 100, 90, MODE_EITHER, 0));
        pending_q.push_back(mk(OP_INSERT, 100, 200, MODE_EITHER, 0));
        pending_q.push_back(mk(OP_INSERT, 150, 160, MODE_EITHER, 0));
        pending_q.push_back(mk(OP_INSERT, 50, 150, MODE_EITHER, 0));
        pending_q.push_back(mk(OP_INSERT, 50, 99, MODE_LEFT, 0));
        pending_q.push_back(mk(OP_INSERT, 40, 49, MODE_EITHER, 0));
        pending_q.push_back(mk(OP_INSERT, 300, 400, MODE_EITHER, 0));
        pending_q.push_back(mk(OP_INSERT, 201, 350, MODE_EITHER, 0));
        pending_q.push_back(mk(OP_INSERT, 201, 299, MODE_LEFT, 0));
        pending_q.push_back(mk(OP_INSERT, 500, 600, MODE_EITHER, 0));
        pending_q.push_back(mk(OP_INSERT, 401, 499, MODE_RIGHT, 0));
        pending_q.push_back(mk(OP_INSERT, 601, 700, MODE_SPARE, 0));
        pending_q.push_back(mk(OP_INSERT, 702, 800, MODE_EITHER, 0));
        pending_q.push_back(mk(OP_INSERT, 701, 701, MODE_SPARE, 0));
        pending_q.push_back(mk(OP_FIND, 0, 0, MODE_EITHER, 45));
        pending_q.push_back(mk(OP_FIND, 0, 0, MODE_EITHER, 10));
        pending_q.push_back(mk(OP_FIND, 0, 0, MODE_EITHER, 900));
        pending_q.push_back(mk(OP_INSERT, 32'hFFFF_FF00, 32'hFFFF_FFFF, MODE_EITHER, 0));
        pending_q.push_back(mk(OP_INSERT, 0, 39, MODE_EITHER, 0));
        pending_q.push_back(mk(OP_INSERT, 801, 32'hFFFF_FEFF, MODE_EITHER, 0));
        pending_q.push_back(mk(OP_FIND, 0, 0, MODE_EITHER, 32'hFFFF_FFFF));
        pending_q.push_back(mk(OP_NONE, 32'hFFFF_FFFF, 0, MODE_SPARE, 32'hFFFF_FFFF));
        pending_q.push_back(mk(OP_CLEAR, 0, 0, MODE_EITHER, 0));

        // fill the table to exhaustion
        for (int i = 0; i < RANGE_SLOTS + 2; i++)
            pending_q.push_back(mk(OP_INSERT, i * 4, i * 4 + 1, MODE_EITHER, 0));
        pending_q.push_back(mk(OP_FIND, 0, 0, MODE_EITHER, 1));
        pending_q.push_back(mk(OP_INSERT, 2, 2, MODE_RIGHT, 0));
        drain();

        // receiver holds off while the sender keeps offering
        hold_rx = 1'b1;
        for (int i = 0; i < 20; i++)
            pending_q.push_back(mk(OP_FIND, 0, 0, MODE_EITHER, $urandom_range(300)));
        repeat (300) @(posedge i_clk);
        hold_rx = 1'b0;
        drain();

        // random, with a stretch of no idling in the middle
        for (int b = 0; b < 6; b++) begin
            base = (b == 5) ? 32'hFFFF_FF80 : $urandom;
            no_idle = (b == 2);
            pending_q.push_back(mk(OP_CLEAR, $urandom, $urandom, 2'($urandom), $urandom));
            for (int i = 0; i < 90; i++) pending_q.push_back(rand_item(base));
            drain();
        end
        no_idle = 0;
        repeat (50) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("sorted_id_range_set: match");
        else
            $display("sorted_id_range_set: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
